// ===== sv/vpus_pkg.sv =====
// Package for the vehicle power-up supervisor: field widths, register indexes,
// action and relay codes, reset values and fixed thresholds.
// No dependencies.
package vpus_pkg;

  localparam int CNT_W    = 8;
  localparam int PCT_W    = 7;
  localparam int VOLT_W   = 16;
  localparam int PRESS_W  = 16;
  localparam int THR_W    = 10;
  localparam int MASK_W   = 5;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;
  localparam int NUM_MOTORS = 2;

  localparam logic [PCT_W-1:0]  PEDAL_MAX_PCT  = 7'd100;
  localparam logic [VOLT_W-1:0] BAT_MIN_VOLT   = 16'd300;
  localparam logic [THR_W-1:0]  THR_MAX        = 10'd999;
  localparam logic [13:0]       THR_STOP_BELOW = 14'd10;
  localparam logic [13:0]       THR_ROUND      = 14'd5;
  localparam logic [12:0]       RECIP_TEN      = 13'd6554;

  localparam logic [CNT_W-1:0]   RST_PEDAL_TIMEOUT = 8'd2;
  localparam logic [CNT_W-1:0]   RST_PEDAL_FAIL    = 8'd2;
  localparam logic [CNT_W-1:0]   RST_MOTOR_TIMEOUT = 8'd5;
  localparam logic [CNT_W-1:0]   RST_BMS_TIMEOUT   = 8'd5;
  localparam logic [CNT_W-1:0]   RST_RELAY_TIMEOUT = 8'd5;
  localparam logic [PCT_W-1:0]   RST_MAX_THROTTLE  = 7'd10;
  localparam logic [PRESS_W-1:0] RST_BRAKE_VALID   = 16'd3000;
  localparam logic [PRESS_W-1:0] RST_BRAKE_LIGHT   = 16'd5600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEDAL_TIMEOUT = 3'd0,
    REG_PEDAL_FAIL    = 3'd1,
    REG_MOTOR_TIMEOUT = 3'd2,
    REG_BMS_TIMEOUT   = 3'd3,
    REG_RELAY_TIMEOUT = 3'd4,
    REG_MAX_THROTTLE  = 3'd5,
    REG_BRAKE_VALID   = 3'd6,
    REG_BRAKE_LIGHT   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REQ_SPD  = 2'd1,
    ACT_STOP     = 2'd2,
    ACT_THROTTLE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RELAY_AIR       = 2'd0,
    RELAY_PRECHARGE = 2'd1,
    RELAY_UNKNOWN   = 2'd2
  } relay_state_t;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPEED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TORQUE  = 2'd2;

  // Packed so that the first member lands in the highest bits.
  typedef struct packed {
    logic [THR_W-1:0] right_throttle;
    action_t          right_action;
    logic [THR_W-1:0] left_throttle;
    action_t          left_action;
    logic             brake_light;
    logic             loop_closed;
    logic             relay_command;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== sv/vehicle_power_up_supervisor.sv =====
// Top level of the vehicle power-up supervisor: liveness tracking, relay and
// shutdown-loop control, motor commands and brake light in one pass.
// Depends on vpus_pkg.
//
//   port group | role   | tdata fields, lowest bit up
//   in_*       | slave  | one control frame of sensor and controller data
//   out_*      | master | relay, loop, brake light and both motor commands
//   cfg_*      | write  | eight threshold and scaling registers
//
// Each frame is handled in one pass: the combinational update runs from the
// state registers and the incoming transaction straight into the result register.
// A new transaction is taken every cycle while the result register is empty or
// being drained; a stalled result holds the input side for as long as the stall lasts.
// Synchronous reset clears all state but the result data and loads the register defaults.
module vehicle_power_up_supervisor
  import vpus_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fresh_mask[4:0], pedal_good[5], pedal_pos[12:6], battery_voltage[28:13],
  // relay_report[29], left_mode[31:30], left_voltage[47:32], right_mode[49:48],
  // right_voltage[65:50], brake_pressure[81:66], zero fill above.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // relay_command[0], loop_closed[1], brake_light[2], left_action[4:3],
  // left_throttle[14:5], right_action[16:15], right_throttle[26:17], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]   pedal_timeout_r, pedal_fail_r, motor_timeout_r;
  logic [CNT_W-1:0]   bms_timeout_r, relay_timeout_r;
  logic [PCT_W-1:0]   max_throttle_r;
  logic [PRESS_W-1:0] brake_valid_r, brake_light_r;

  logic               pedal_alive_r, pedal_alive_nxt;
  logic [CNT_W-1:0]   pedal_silent_r, pedal_silent_nxt;
  logic [CNT_W-1:0]   pedal_bad_r, pedal_bad_nxt;
  logic               pedal_ever_r, pedal_ever_nxt;
  logic [PCT_W-1:0]   pedal_pos_r, pedal_pos_nxt;
  logic               bms_alive_r, bms_alive_nxt;
  logic [CNT_W-1:0]   bms_silent_r, bms_silent_nxt;
  logic [VOLT_W-1:0]  bat_volt_r, bat_volt_nxt;
  logic               relay_alive_r, relay_alive_nxt;
  logic [CNT_W-1:0]   relay_silent_r, relay_silent_nxt;
  relay_state_t       relay_state_r, relay_state_nxt;
  logic [NUM_MOTORS-1:0] mot_alive_r, mot_alive_nxt;
  logic [CNT_W-1:0]   mot_silent_r [NUM_MOTORS];
  logic [CNT_W-1:0]   mot_silent_nxt [NUM_MOTORS];
  logic [MODE_W-1:0]  mot_mode_r [NUM_MOTORS];
  logic [MODE_W-1:0]  mot_mode_nxt [NUM_MOTORS];
  logic [VOLT_W-1:0]  mot_volt_r [NUM_MOTORS];
  logic [VOLT_W-1:0]  mot_volt_nxt [NUM_MOTORS];
  logic               precharge_done_r, precharge_done_nxt;

  logic               out_valid_r;
  result_t            result_r, result_nxt;

  logic               in_fire;
  logic [MASK_W-1:0]  fresh_mask;
  logic               pedal_good;
  logic [PCT_W-1:0]   pedal_pos;
  logic [VOLT_W-1:0]  battery_voltage;
  logic               relay_report;
  logic [MODE_W-1:0]  in_mode [NUM_MOTORS];
  logic [VOLT_W-1:0]  in_volt [NUM_MOTORS];
  logic [PRESS_W-1:0] brake_pressure;

  logic               intact, over, both, relay_air, loop_on, pd_set, enable;
  logic [13:0]        thr_prod;
  logic [27:0]        thr_scaled;
  logic [THR_W-1:0]   thr_val;
  logic               thr_stop;
  logic [20:0]        bat_x19;
  logic [20:0]        mot_x20 [NUM_MOTORS];
  action_t            mot_act [NUM_MOTORS];
  logic [THR_W-1:0]   mot_thr [NUM_MOTORS];

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, result_r};

  assign fresh_mask      = in_tdata[4:0];
  assign pedal_good      = in_tdata[5];
  assign pedal_pos       = in_tdata[12:6];
  assign battery_voltage = in_tdata[28:13];
  assign relay_report    = in_tdata[29];
  assign in_mode[0]      = in_tdata[31:30];
  assign in_volt[0]      = in_tdata[47:32];
  assign in_mode[1]      = in_tdata[49:48];
  assign in_volt[1]      = in_tdata[65:50];
  assign brake_pressure  = in_tdata[81:66];

  always_comb begin
    pedal_alive_nxt  = pedal_alive_r;
    pedal_silent_nxt = pedal_silent_r;
    pedal_bad_nxt    = pedal_bad_r;
    pedal_ever_nxt   = pedal_ever_r;
    pedal_pos_nxt    = pedal_pos_r;
    if (fresh_mask[0]) begin
      pedal_silent_nxt = '0;
      if (pedal_good && pedal_pos <= PEDAL_MAX_PCT) begin
        pedal_bad_nxt   = '0;
        pedal_alive_nxt = 1'b1;
        pedal_pos_nxt   = pedal_pos;
        pedal_ever_nxt  = 1'b1;
      end else begin
        pedal_bad_nxt = sat_inc(pedal_bad_r);
        if (pedal_bad_nxt >= pedal_fail_r) begin
          pedal_alive_nxt = 1'b0;
        end
      end
    end else begin
      pedal_silent_nxt = sat_inc(pedal_silent_r);
      if (pedal_silent_nxt >= pedal_timeout_r) begin
        pedal_alive_nxt = 1'b0;
      end
    end

    bms_alive_nxt  = bms_alive_r;
    bms_silent_nxt = bms_silent_r;
    bat_volt_nxt   = bat_volt_r;
    if (fresh_mask[1]) begin
      bms_silent_nxt = '0;
      bms_alive_nxt  = 1'b1;
      bat_volt_nxt   = battery_voltage;
    end else begin
      bms_silent_nxt = sat_inc(bms_silent_r);
      if (bms_silent_nxt > bms_timeout_r) begin
        bms_alive_nxt = 1'b0;
      end
    end

    relay_alive_nxt  = relay_alive_r;
    relay_silent_nxt = relay_silent_r;
    relay_state_nxt  = relay_state_r;
    if (fresh_mask[2]) begin
      relay_silent_nxt = '0;
      relay_alive_nxt  = 1'b1;
      relay_state_nxt  = relay_report ? RELAY_PRECHARGE : RELAY_AIR;
    end else begin
      relay_silent_nxt = sat_inc(relay_silent_r);
      if (relay_silent_nxt >= relay_timeout_r) begin
        relay_alive_nxt = 1'b0;
      end
    end

    for (int m = 0; m < NUM_MOTORS; m++) begin
      mot_alive_nxt[m]  = mot_alive_r[m];
      mot_silent_nxt[m] = mot_silent_r[m];
      mot_mode_nxt[m]   = mot_mode_r[m];
      mot_volt_nxt[m]   = mot_volt_r[m];
      if (fresh_mask[3+m]) begin
        mot_silent_nxt[m] = '0;
        if (in_mode[m] == MODE_SPEED || in_mode[m] == MODE_TORQUE) begin
          mot_alive_nxt[m] = 1'b1;
          mot_mode_nxt[m]  = in_mode[m];
          mot_volt_nxt[m]  = in_volt[m];
        end else begin
          mot_alive_nxt[m] = 1'b0;
        end
      end else begin
        mot_silent_nxt[m] = sat_inc(mot_silent_r[m]);
        if (mot_silent_nxt[m] >= motor_timeout_r) begin
          mot_alive_nxt[m] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    bat_x19 = {1'b0, bat_volt_nxt, 4'b0} + {3'b0, bat_volt_nxt, 1'b0} +
              {5'b0, bat_volt_nxt};
    for (int m = 0; m < NUM_MOTORS; m++) begin
      mot_x20[m] = {1'b0, mot_volt_nxt[m], 4'b0} + {3'b0, mot_volt_nxt[m], 2'b0};
    end
    intact = pedal_alive_nxt && bms_alive_nxt && relay_alive_nxt &&
             (brake_pressure > brake_valid_r);
    over   = (mot_x20[0] > bat_x19) && (mot_x20[1] > bat_x19) &&
             (bat_volt_nxt > BAT_MIN_VOLT);
    both   = mot_alive_nxt[0] && mot_alive_nxt[1];
    relay_air = intact && both && (over || precharge_done_r);
    pd_set    = precharge_done_r || relay_air;
    loop_on   = intact && (relay_state_nxt == RELAY_PRECHARGE || pd_set);
    precharge_done_nxt = loop_on && pd_set;
    enable = intact && both && (relay_state_nxt == RELAY_AIR);

    thr_prod   = {7'b0, pedal_pos_nxt} * {7'b0, max_throttle_r};
    thr_scaled = {14'b0, thr_prod + THR_ROUND} * {15'b0, RECIP_TEN};
    thr_stop   = (pedal_pos_nxt == '0) || (thr_prod < THR_STOP_BELOW);
    thr_val    = (thr_scaled[27:16] > {2'b0, THR_MAX}) ? THR_MAX : thr_scaled[25:16];

    for (int m = 0; m < NUM_MOTORS; m++) begin
      mot_act[m] = ACT_NONE;
      mot_thr[m] = '0;
      if (enable) begin
        if (mot_mode_nxt[m] != MODE_SPEED) begin
          mot_act[m] = ACT_REQ_SPD;
        end else if (pedal_ever_nxt) begin
          if (thr_stop) begin
            mot_act[m] = ACT_STOP;
          end else begin
            mot_act[m] = ACT_THROTTLE;
            mot_thr[m] = thr_val;
          end
        end
      end
    end

    result_nxt.relay_command  = !relay_air;
    result_nxt.loop_closed    = loop_on;
    result_nxt.brake_light    = brake_pressure > brake_light_r;
    result_nxt.left_action    = mot_act[0];
    result_nxt.left_throttle  = mot_thr[0];
    result_nxt.right_action   = mot_act[1];
    result_nxt.right_throttle = mot_thr[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedal_timeout_r <= RST_PEDAL_TIMEOUT;
      pedal_fail_r    <= RST_PEDAL_FAIL;
      motor_timeout_r <= RST_MOTOR_TIMEOUT;
      bms_timeout_r   <= RST_BMS_TIMEOUT;
      relay_timeout_r <= RST_RELAY_TIMEOUT;
      max_throttle_r  <= RST_MAX_THROTTLE;
      brake_valid_r   <= RST_BRAKE_VALID;
      brake_light_r   <= RST_BRAKE_LIGHT;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PEDAL_TIMEOUT: pedal_timeout_r <= cfg_wdata[CNT_W-1:0];
        REG_PEDAL_FAIL:    pedal_fail_r    <= cfg_wdata[CNT_W-1:0];
        REG_MOTOR_TIMEOUT: motor_timeout_r <= cfg_wdata[CNT_W-1:0];
        REG_BMS_TIMEOUT:   bms_timeout_r   <= cfg_wdata[CNT_W-1:0];
        REG_RELAY_TIMEOUT: relay_timeout_r <= cfg_wdata[CNT_W-1:0];
        REG_MAX_THROTTLE:  max_throttle_r  <= cfg_wdata[PCT_W-1:0];
        REG_BRAKE_VALID:   brake_valid_r   <= cfg_wdata[PRESS_W-1:0];
        REG_BRAKE_LIGHT:   brake_light_r   <= cfg_wdata[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedal_alive_r    <= 1'b0;
      pedal_silent_r   <= '0;
      pedal_bad_r      <= '0;
      pedal_ever_r     <= 1'b0;
      pedal_pos_r      <= '0;
      bms_alive_r      <= 1'b0;
      bms_silent_r     <= '0;
      bat_volt_r       <= '0;
      relay_alive_r    <= 1'b0;
      relay_silent_r   <= '0;
      relay_state_r    <= RELAY_UNKNOWN;
      mot_alive_r      <= '0;
      precharge_done_r <= 1'b0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        mot_silent_r[m] <= '0;
        mot_mode_r[m]   <= MODE_UNKNOWN;
        mot_volt_r[m]   <= '0;
      end
    end else if (in_fire) begin
      pedal_alive_r    <= pedal_alive_nxt;
      pedal_silent_r   <= pedal_silent_nxt;
      pedal_bad_r      <= pedal_bad_nxt;
      pedal_ever_r     <= pedal_ever_nxt;
      pedal_pos_r      <= pedal_pos_nxt;
      bms_alive_r      <= bms_alive_nxt;
      bms_silent_r     <= bms_silent_nxt;
      bat_volt_r       <= bat_volt_nxt;
      relay_alive_r    <= relay_alive_nxt;
      relay_silent_r   <= relay_silent_nxt;
      relay_state_r    <= relay_state_nxt;
      mot_alive_r      <= mot_alive_nxt;
      precharge_done_r <= precharge_done_nxt;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        mot_silent_r[m] <= mot_silent_nxt[m];
        mot_mode_r[m]   <= mot_mode_nxt[m];
        mot_volt_r[m]   <= mot_volt_nxt[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_thr_zero_unless_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.left_action != ACT_THROTTLE |-> result_r.left_throttle == '0)
    else $error("left throttle nonzero without throttle action");

  a_thr_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (result_r.left_throttle <= THR_MAX && result_r.right_throttle <= THR_MAX))
    else $error("throttle above maximum");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted frame produced no result");

  a_precharge_needs_loop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !result_nxt.loop_closed |=> !precharge_done_r)
    else $error("precharge done latched with loop open");

  a_air_needs_loop_or_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !result_r.relay_command |-> result_r.loop_closed)
    else $error("AIR commanded with shutdown loop open");
`endif

endmodule
